>>> rtl/core/fpq_pkg.sv
`default_nettype none
package fpq_pkg;

  localparam logic [1:0] FMT_E4M3 = 2'd0;
  localparam logic [1:0] FMT_E5M2 = 2'd1;
  localparam logic [1:0] FMT_E2M1 = 2'd2;
  localparam logic [1:0] FMT_E3M0 = 2'd3;

  localparam logic [1:0] KIND_NUM  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_INF  = 2'd2;
  localparam logic [1:0] KIND_NAN  = 2'd3;

  localparam logic [7:0]  EXP_ONES  = 8'hFF;
  localparam logic [9:0]  FP32_BIAS = 10'd127;
  localparam logic [23:0] HIDDEN    = 24'h800000;

  typedef struct packed {
    logic [2:0] eb;
    logic [1:0] mb;
    logic [4:0] bias;
    logic       has_inf;
    logic       nan_top;
  } spec_t;

  typedef struct packed {
    logic              sign;
    logic [1:0]        fmt;
    logic [1:0]        kind;
    logic              subn;
    logic signed [9:0] et;
    logic [23:0]       mf;
    logic [5:0]        sh;
  } s1_t;

  typedef struct packed {
    logic              sign;
    logic [1:0]        fmt;
    logic [1:0]        kind;
    logic              subn;
    logic signed [9:0] et;
    logic [4:0]        r;
  } s2_t;

  function automatic spec_t fpq_spec(input logic [1:0] fmt);
    spec_t s;
    case (fmt)
      FMT_E4M3: s = '{eb: 3'd4, mb: 2'd3, bias: 5'd7,  has_inf: 1'b0, nan_top: 1'b1};
      FMT_E5M2: s = '{eb: 3'd5, mb: 2'd2, bias: 5'd15, has_inf: 1'b1, nan_top: 1'b0};
      FMT_E2M1: s = '{eb: 3'd2, mb: 2'd1, bias: 5'd1,  has_inf: 1'b0, nan_top: 1'b0};
      default:  s = '{eb: 3'd3, mb: 2'd0, bias: 5'd3,  has_inf: 1'b0, nan_top: 1'b0};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/fpq_if.sv
`default_nettype none
interface fpq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface fpq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_code;
  modport source (output valid, output packed_code, input ready);
  modport sink (input valid, input packed_code, output ready);
endinterface

interface fpq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] target_format;
  modport source (output valid, output target_format, input ready);
  modport sink (input valid, input target_format, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fpq_decode.sv
`default_nettype none
module fpq_decode import fpq_pkg::*; (
  input  wire logic [31:0] value_bits,
  input  wire logic [1:0]  fmt,
  output s1_t              dec
);
  spec_t             s;
  logic [7:0]        e32;
  logic [22:0]       m32;
  logic signed [9:0] et;
  logic [9:0]        extra;
  logic [9:0]        sh_w;

  always_comb begin
    s     = fpq_spec(fmt);
    e32   = value_bits[30:23];
    m32   = value_bits[22:0];
    et    = $signed({2'b00, e32}) - $signed(FP32_BIAS) + $signed({5'b00000, s.bias});
    extra = 10'd1 - $unsigned(et);
    dec.sign = value_bits[31];
    dec.fmt  = fmt;
    dec.et   = et;
    dec.mf   = {1'b0, m32} | HIDDEN;
    dec.subn = (et <= 10'sd0);
    dec.kind = KIND_NUM;
    if (dec.subn) begin
      sh_w = 10'd23 - {8'd0, s.mb} + extra;
    end else begin
      sh_w = 10'd23 - {8'd0, s.mb};
    end
    dec.sh = sh_w[5:0];
    if (e32 == EXP_ONES) begin
      dec.kind = (m32 != 23'd0) ? KIND_NAN : KIND_INF;
    end else if (e32 == 8'd0) begin
      dec.kind = KIND_ZERO;
    end else if (dec.subn && (extra > 10'd24 || sh_w >= 10'd32)) begin
      dec.kind = KIND_ZERO;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/fpq_round.sv
`default_nettype none
module fpq_round import fpq_pkg::*; (
  input  wire s1_t a,
  output s2_t b
);
  logic [4:0]  sh;
  logic [23:0] shifted;
  logic [23:0] half_vec;
  logic [23:0] rest_mask;
  logic        half;
  logic        sticky;

  always_comb begin
    sh        = a.sh[4:0];
    shifted   = a.mf >> sh;
    half_vec  = a.mf >> (sh - 5'd1);
    half      = half_vec[0];
    rest_mask = (24'd1 << (sh - 5'd1)) - 24'd1;
    sticky    = (a.mf & rest_mask) != 24'd0;
    b.sign = a.sign;
    b.fmt  = a.fmt;
    b.kind = a.kind;
    b.subn = a.subn;
    b.et   = a.et;
    b.r    = shifted[4:0] + {4'd0, half & (sticky | shifted[0])};
  end
endmodule
`default_nettype wire

>>> rtl/core/fpq_pack.sv
`default_nettype none
module fpq_pack import fpq_pkg::*; (
  input  wire s2_t        a,
  output logic [7:0]      code
);
  spec_t             s;
  logic [7:0]        sgn;
  logic [7:0]        maxexp;
  logic [7:0]        mmask;
  logic [7:0]        top;
  logic [7:0]        satmag;
  logic [7:0]        ovf_code;
  logic [4:0]        ms;
  logic signed [9:0] etn;
  logic              ovf;

  always_comb begin
    s        = fpq_spec(a.fmt);
    sgn      = {7'd0, a.sign} << ({1'b0, s.eb} + {2'b00, s.mb});
    maxexp   = (8'd1 << s.eb) - 8'd1;
    mmask    = (8'd1 << s.mb) - 8'd1;
    top      = maxexp << s.mb;
    satmag   = s.nan_top ? (top | (mmask - 8'd1)) : (top | mmask);
    ovf_code = s.has_inf ? (sgn | top) : (sgn | satmag);
    ms       = a.r;
    etn      = a.et;
    if ({3'd0, a.r} >= (8'd2 << s.mb)) begin
      ms  = a.r >> 1;
      etn = a.et + 10'sd1;
    end
    ms = ms & mmask[4:0];
    if (s.has_inf) begin
      ovf = etn >= $signed({2'b00, maxexp});
    end else if (s.nan_top) begin
      ovf = etn > $signed({2'b00, maxexp}) ||
            (etn == $signed({2'b00, maxexp}) && {3'd0, ms} == mmask);
    end else begin
      ovf = etn > $signed({2'b00, maxexp});
    end
    case (a.kind)
      KIND_NAN:  code = sgn | top | (s.has_inf ? 8'd1 : mmask);
      KIND_INF:  code = ovf_code;
      KIND_ZERO: code = sgn;
      default: begin
        if (a.subn) begin
          code = sgn | {3'd0, a.r};
        end else if (ovf) begin
          code = ovf_code;
        end else begin
          code = sgn | (etn[7:0] << s.mb) | {3'd0, ms};
        end
      end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/core/fp32_to_minifloat_quantizer.sv
`default_nettype none
// Converts one IEEE single bit pattern per beat into an E4M3, E5M2, E2M1 or E3M0 code chosen
// by target_format, rounding to nearest even. Three register stages (decode, round, pack);
// a beat is taken every cycle unless the output stalls, and its code passes through the
// decode, round and pack registers in order. A stall at the output holds the whole pipeline.
// FP4 codes sit in the low four bits. Write target_format only while no beat is in flight.
module fp32_to_minifloat_quantizer import fpq_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  fpq_in_if.sink    sample,
  fpq_out_if.source result,
  fpq_cfg_if.sink   cfg
);
  logic [1:0] fmt;
  logic       adv;
  logic       v1, v2, v3;
  s1_t        d1, q1;
  s2_t        d2, q2;
  logic [7:0] d3, q3;
  logic [1:0] fmt3;

  assign adv          = !v3 || result.ready;
  assign sample.ready = adv;
  assign cfg.ready    = 1'b1;

  fpq_decode u_decode (.value_bits(sample.value_bits), .fmt(fmt), .dec(d1));
  fpq_round  u_round  (.a(q1), .b(d2));
  fpq_pack   u_pack   (.a(q2), .code(d3));

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_E4M3;
    end else if (cfg.valid) begin
      fmt <= cfg.target_format;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1   <= d1;
      q2   <= d2;
      q3   <= d3;
      fmt3 <= q2.fmt;
    end
  end

  assign result.valid       = v3;
  assign result.packed_code = q3;

  // fp4 codes keep the upper nibble clear
  a_fp4_nibble: assert property (@(posedge clk) disable iff (rst)
    (v3 && (fmt3 == FMT_E2M1 || fmt3 == FMT_E3M0)) |-> (q3[7:4] == 4'd0))
    else $error("fp4 code has upper bits set");

  // a stalled pipeline keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !result.ready) |=> (v3 && $stable(q3) && $stable(v2) && $stable(v1)))
    else $error("pipeline moved during stall");

  // e5m2 never emits a code with all-ones exponent and mantissa above one
  a_e5m2_nan: assert property (@(posedge clk) disable iff (rst)
    (v3 && fmt3 == FMT_E5M2 && q3[6:2] == 5'h1F) |-> (q3[1] == 1'b0))
    else $error("bad e5m2 special code");
endmodule
`default_nettype wire

>>> verif/fpq_tb_scoreboard.sv
`timescale 1ns / 1ps
class fpq_code_scoreboard;
  logic [7:0] expected_codes[$];
  logic [31:0] expected_inputs[$];
  int mismatch_count;
  int checked_count;
  logic [1:0] fmt;

  function new();
    mismatch_count = 0;
    checked_count = 0;
    fmt = fpq_pkg::FMT_E4M3;
  endfunction

  static function logic [31:0] rne(logic [31:0] m, int unsigned sh);
    logic [31:0] half_bit, rest, r;
    if (sh == 0) return m;
    if (sh >= 32) return 0;
    half_bit = (m >> (sh - 1)) & 1;
    rest = m & ((32'd1 << (sh - 1)) - 1);
    r = m >> sh;
    if (half_bit != 0 && (rest != 0 || r[0])) r = r + 1;
    return r;
  endfunction

  function logic [7:0] quantize(logic [31:0] u);
    int unsigned eb, mb;
    int bias, et;
    bit has_inf, nan_top, ovf;
    logic [31:0] sgn, maxexp, mmask, top, satmag, ovf_code, mf, ms, code;
    logic [7:0] e32;
    logic [22:0] m32;
    case (fmt)
      fpq_pkg::FMT_E4M3: begin eb = 4; mb = 3; bias = 7;  has_inf = 0; nan_top = 1; end
      fpq_pkg::FMT_E5M2: begin eb = 5; mb = 2; bias = 15; has_inf = 1; nan_top = 0; end
      fpq_pkg::FMT_E2M1: begin eb = 2; mb = 1; bias = 1;  has_inf = 0; nan_top = 0; end
      default: begin eb = 3; mb = 0; bias = 3; has_inf = 0; nan_top = 0; end
    endcase
    e32 = u[30:23];
    m32 = u[22:0];
    sgn = 32'(u[31]) << (eb + mb);
    maxexp = (32'd1 << eb) - 1;
    mmask = (32'd1 << mb) - 1;
    top = maxexp << mb;
    satmag = nan_top ? (top | (mmask - 1)) : (top | mmask);
    ovf_code = has_inf ? (sgn | top) : (sgn | satmag);
    if (e32 == 8'hFF) begin
      code = (m32 != 0) ? (sgn | top | (has_inf ? 32'd1 : mmask)) : ovf_code;
    end else if (e32 == 0) begin
      code = sgn;
    end else begin
      et = int'(e32) - 127 + bias;
      mf = {8'd0, 1'b1, m32};
      if (et <= 0) begin
        if (1 - et > 24) code = sgn;
        else code = sgn | rne(mf, 23 - mb + (1 - et));
      end else begin
        ms = rne(mf, 23 - mb);
        if (ms >= (32'd2 << mb)) begin
          ms = ms >> 1;
          et++;
        end
        ms = ms & mmask;
        if (has_inf) ovf = et >= int'(maxexp);
        else if (nan_top) ovf = et > int'(maxexp) || (et == int'(maxexp) && ms == mmask);
        else ovf = et > int'(maxexp);
        code = ovf ? ovf_code : (sgn | (32'(et) << mb) | ms);
      end
    end
    return code[7:0];
  endfunction

  function void note_sample(logic [31:0] u);
    expected_codes.push_back(quantize(u));
    expected_inputs.push_back(u);
  endfunction

  function bit check_code(logic [7:0] got, output string msg);
    logic [7:0] want;
    logic [31:0] u;
    checked_count++;
    if (expected_codes.size() == 0) begin
      msg = $sformatf("unexpected result beat code %02h", got);
      return 0;
    end
    want = expected_codes.pop_front();
    u = expected_inputs.pop_front();
    if (want !== got) begin
      msg = $sformatf("input %08h fmt %0d: packed_code %02h, want %02h", u, fmt, got, want);
      return 0;
    end
    return 1;
  endfunction
endclass

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fpq_pkg::*;

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  fpq_in_if sample();
  fpq_out_if result();
  fpq_cfg_if cfg();

  fp32_to_minifloat_quantizer DUT (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source), .cfg(cfg.sink)
  );

  fpq_code_scoreboard board;
  int fail_count = 0;
  int idle_cycles = 0;
  int sent_count = 0;
  bit calm = 0;
  bit stall_ok = 0;
  int fmt_seen[4];

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch: %s", msg);
  endtask

  initial begin
    sample.valid = 0;
    sample.value_bits = 0;
    result.ready = 0;
    cfg.valid = 0;
    cfg.target_format = 0;
    board = new();
  end

  // output side: check and random backpressure
  always @(posedge clk) begin
    string msg;
    if (!rst && result.valid && result.ready) begin
      if (!board.check_code(result.packed_code, msg)) report_mismatch(msg);
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (!calm && stall_ok && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 14);
        result.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1;
      @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("watchdog: no progress");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_value(logic [31:0] u);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      sample.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1;
    sample.value_bits <= u;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    board.note_sample(u);
    fmt_seen[board.fmt]++;
    sent_count++;
  endtask

  task automatic drain();
    sample.valid <= 0;
    while (board.expected_codes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_format(logic [1:0] f);
    drain();
    cfg.valid <= 1;
    cfg.target_format <= f;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 0;
    board.fmt = f;
  endtask

  function automatic logic [31:0] pick_value(logic [1:0] f);
    logic [31:0] u;
    int lo, hi;
    u = $urandom;
    case (f)
      FMT_E4M3: begin lo = 127 - 12; hi = 127 + 10; end
      FMT_E5M2: begin lo = 127 - 19; hi = 127 + 17; end
      FMT_E2M1: begin lo = 127 - 3;  hi = 127 + 4;  end
      default:  begin lo = 127 - 6;  hi = 127 + 6;  end
    endcase
    case ($urandom_range(0, 9))
      0: u[30:23] = 8'hFF;
      1: u[30:23] = 0;
      2: ;
      3: u[22:0] = {4'($urandom_range(0, 15)), 19'h40000} |
                   {22'd0, ~1'($urandom_range(0, 1))};
      default: u[30:23] = 8'($urandom_range(lo, hi));
    endcase
    return u;
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [1:0] fmts[6];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    stall_ok = 1;
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFF80_0001,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000,
                 32'h43E0_0000, 32'h43F0_0000, 32'h43E8_0000, 32'h40C0_0000,
                 32'h40E0_0000, 32'h4180_0000, 32'h3B00_0000, 32'h3A80_0000,
                 32'h3F88_0000, 32'h3F98_0000, 32'h3E80_0000, 32'h0080_0000,
                 32'hFFFF_FFFF};
    fmts = '{FMT_E4M3, FMT_E5M2, FMT_E2M1, FMT_E3M0, FMT_E4M3, FMT_E3M0};
    foreach (directed[i]) send_value(directed[i]);
    for (int f = 1; f < 4; f++) begin
      write_format(2'(f));
      foreach (directed[i]) send_value(directed[i]);
    end
    for (int p = 0; p < 6; p++) begin
      write_format(fmts[p]);
      if (p == 5) calm = 1;
      for (int i = 0; i < 230; i++) send_value(pick_value(fmts[p]));
    end
    drain();
    $display("covered %0d beats: e4m3 %0d, e5m2 %0d, e2m1 %0d, e3m0 %0d", sent_count,
             fmt_seen[0], fmt_seen[1], fmt_seen[2], fmt_seen[3]);
    $display("results checked %0d, mismatches %0d", board.checked_count, fail_count);
    if (fail_count == 0 && board.expected_codes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> fp32_to_minifloat_quantizer.f
rtl/core/fpq_pkg.sv
rtl/core/fpq_if.sv
rtl/core/fpq_decode.sv
rtl/core/fpq_round.sv
rtl/core/fpq_pack.sv
rtl/core/fp32_to_minifloat_quantizer.sv
verif/fpq_tb_scoreboard.sv
verif/testbench.sv
